FILE: src/sme_pkg.sv
`default_nettype none
package sme_pkg;

  // default sizes of the data stack and the constant pool
  localparam int unsigned StackDepthDef = 256;
  localparam int unsigned PoolDepthDef  = 256;

  // fixed field widths
  localparam int unsigned WordW = 64;
  localparam int unsigned IpW   = 24;
  localparam int unsigned StatW = 3;
  localparam int unsigned DepW  = 9;

  // opcodes
  localparam logic [7:0] OP_PUSH  = 8'd0;
  localparam logic [7:0] OP_POP   = 8'd1;
  localparam logic [7:0] OP_ADD   = 8'd2;
  localparam logic [7:0] OP_SUB   = 8'd3;
  localparam logic [7:0] OP_MUL   = 8'd4;
  localparam logic [7:0] OP_DIV   = 8'd5;
  localparam logic [7:0] OP_NEG   = 8'd6;
  localparam logic [7:0] OP_NOT   = 8'd7;
  localparam logic [7:0] OP_AND   = 8'd8;
  localparam logic [7:0] OP_OR    = 8'd9;
  localparam logic [7:0] OP_LOAD  = 8'd10;
  localparam logic [7:0] OP_STLOC = 8'd11;
  localparam logic [7:0] OP_JMP   = 8'd12;
  localparam logic [7:0] OP_JIF   = 8'd13;
  localparam logic [7:0] OP_CALL  = 8'd14;
  localparam logic [7:0] OP_RET   = 8'd15;
  localparam logic [7:0] OP_EMIT  = 8'd16;
  localparam logic [7:0] OP_HALT  = 8'd17;

  // status codes
  localparam logic [StatW-1:0] ST_RUN  = 3'd0;
  localparam logic [StatW-1:0] ST_HALT = 3'd1;
  localparam logic [StatW-1:0] ST_DIVZ = 3'd2;
  localparam logic [StatW-1:0] ST_UNK  = 3'd3;
  localparam logic [StatW-1:0] ST_FULL = 3'd4;

endpackage
`default_nettype wire

FILE: src/stack_machine_execute_core.sv
// a load transaction, or an execute on a stopped core or with ip at or past the length, answers in
// the cycle after start; an instruction passes two stack reads, execute and write back;
// MUL adds a pass through a shared 32x32 multiplier, DIV adds the steps of a bit-serial divider.
// throughput: one transaction at a time, the next start is taken the cycle the result shows.
// reset: asynchronous, then a clearing pass zeroes every entry of the stack memory
// with busy high; the receiver cannot stall, every result is a one-cycle done strobe.
`default_nettype none
module stack_machine_execute_core #(
  parameter int unsigned STACK_DEPTH = sme_pkg::StackDepthDef,
  parameter int unsigned POOL_DEPTH  = sme_pkg::PoolDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        kind_i,
  input  wire logic [31:0] instr_word_i,
  input  wire logic [63:0] const_value_i,
  input  wire logic        cfg_we_i,
  input  wire logic [23:0] cfg_wdata_i,
  output logic             done_o,
  output logic [23:0]      next_ip_o,
  output logic [2:0]       status_o,
  output logic             print_valid_o,
  output logic [63:0]      print_value_o,
  output logic [8:0]       depth_now_o
);
  import sme_pkg::*;

  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned FBW = SPW + 1;
  localparam int unsigned CW  = $clog2(POOL_DEPTH + 1);
  localparam int unsigned PAW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned IW  = 26;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD1   = 4'd2;
  localparam logic [3:0] S_RD2   = 4'd3;
  localparam logic [3:0] S_EXEC  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_DFIN  = 4'd7;
  localparam logic [3:0] S_WB    = 4'd8;

  logic [3:0]       state_q;
  logic [AW-1:0]    clr_q;
  logic [SPW-1:0]   sp_q, sp_d;
  logic [FBW-1:0]   fb_q, fb_d;
  logic [IpW-1:0]   ip_q, ip_d;
  logic [CW-1:0]    cnt_q;
  logic             stopped_q, stopped_d;
  logic [IpW-1:0]   len_q;
  logic [7:0]       op_q;
  logic [IpW-1:0]   arg_q;
  logic [IW-1:0]    idx_q;
  logic [WordW-1:0] t1_q, t2_q, res_q;
  logic             divz_q;
  logic [1:0]       mstep_q;
  logic [WordW-1:0] mprod_q, acc_q;
  logic [6:0]       dcnt_q;
  logic [WordW:0]   rem_q;
  logic [WordW-1:0] quo_q, dvs_q;
  logic             dneg_q;

  logic             done_q, done_d, pvalid_q;
  logic [IpW-1:0]   nip_q;
  logic [StatW-1:0] stat_q, stat_d;
  logic [WordW-1:0] pval_q;
  logic [SPW-1:0]   dep_q;

  // memories
  logic [WordW-1:0] st_mem [STACK_DEPTH];
  logic [WordW-1:0] pool_mem [POOL_DEPTH];
  logic [WordW-1:0] st_rd_q, pool_rd_q;
  logic             st_re, st_we, pool_we;
  logic [AW-1:0]    st_raddr, st_waddr;
  logic [WordW-1:0] st_wdata;

  // stack pointer after one and two pops
  logic [SPW-1:0] sp1, sp2;
  assign sp1 = (sp_q == '0) ? '0 : sp_q - SPW'(1);
  assign sp2 = (sp_q < SPW'(2)) ? '0 : sp_q - SPW'(2);

  logic accept;
  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  // result strobe: immediate answers and the write back cycle
  assign done_d = (accept && (!kind_i || stopped_q || (ip_q >= len_q))) || (state_q == S_WB);

  // frame-relative index for load and store
  logic [IW-1:0] idx_d;
  logic          idx_ok;
  assign idx_d  = {2'b00, instr_word_i[31:8]} + {{(IW - FBW){fb_q[FBW-1]}}, fb_q};
  assign idx_ok = !idx_q[IW-1] && (idx_q < IW'(STACK_DEPTH));

  // stack read port
  always_comb begin
    st_re    = 1'b0;
    st_raddr = AW'(sp_q - SPW'(1));
    if (accept && kind_i) begin
      st_re = 1'b1;
    end else if (state_q == S_RD1) begin
      st_re    = 1'b1;
      st_raddr = (op_q == OP_LOAD) ? idx_q[AW-1:0] : AW'(sp_q - SPW'(2));
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rd_q <= st_mem[st_raddr];
    end
  end

  // constant pool: append on load, read at the argument on execute
  assign pool_we = accept && !kind_i && (cnt_q < CW'(POOL_DEPTH));
  always_ff @(posedge clk_i) begin
    if (pool_we) begin
      pool_mem[cnt_q[PAW-1:0]] <= const_value_i;
    end
    if (accept && kind_i) begin
      pool_rd_q <= pool_mem[instr_word_i[PAW+7:8]];
    end
  end

  // call frame and return pointer
  logic [IW-1:0]  call_f, neg_lim;
  logic [SPW-1:0] ret_sp;
  assign call_f  = IW'(sp_q) - {2'b00, arg_q};
  assign neg_lim = ~IW'(STACK_DEPTH) + IW'(1);
  always_comb begin
    if (fb_q[FBW-1]) begin
      ret_sp = '0;
    end else if (fb_q[SPW-1:0] > SPW'(STACK_DEPTH)) begin
      ret_sp = SPW'(STACK_DEPTH);
    end else begin
      ret_sp = fb_q[SPW-1:0];
    end
  end

  // write back of one instruction
  logic [IpW:0]     nxt;
  logic             wpush;
  logic [SPW-1:0]   wbase;
  logic [WordW-1:0] wval;
  logic             wstore, wpv;
  always_comb begin
    nxt       = {1'b0, ip_q} + (IpW + 1)'(1);
    sp_d      = sp_q;
    fb_d      = fb_q;
    stat_d    = ST_RUN;
    wpush     = 1'b0;
    wbase     = sp_q;
    wval      = res_q;
    wstore    = 1'b0;
    wpv       = 1'b0;
    case (op_q)
      OP_PUSH: begin
        wpush = (arg_q < IpW'(cnt_q));
        wval  = pool_rd_q;
      end
      OP_POP: sp_d = sp1;
      OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR: begin
        wbase = sp2;
        wpush = 1'b1;
      end
      OP_DIV: begin
        wbase = sp2;
        sp_d  = sp2;
        if (divz_q) begin
          stat_d = ST_DIVZ;
          nxt    = {1'b0, ip_q};
        end else begin
          wpush = 1'b1;
        end
      end
      OP_NEG, OP_NOT: begin
        wbase = sp1;
        wpush = 1'b1;
      end
      OP_LOAD: begin
        wpush = idx_ok;
        wval  = t2_q;
      end
      OP_STLOC: begin
        sp_d   = sp1;
        wstore = idx_ok;
      end
      OP_JMP: nxt = {1'b0, arg_q};
      OP_JIF: begin
        sp_d = sp1;
        if (t1_q == '0) begin
          nxt = {1'b0, arg_q};
        end
      end
      OP_CALL: begin
        fb_d = ($signed(call_f) < $signed(neg_lim)) ? neg_lim[FBW-1:0] : call_f[FBW-1:0];
      end
      OP_RET: begin
        wbase = ret_sp;
        sp_d  = ret_sp;
        wpush = 1'b1;
        wval  = t1_q;
      end
      OP_EMIT: begin
        sp_d = sp1;
        wpv  = 1'b1;
      end
      OP_HALT: begin
        stat_d = ST_HALT;
        nxt    = {1'b0, ip_q};
      end
      default: begin
        stat_d = ST_UNK;
        nxt    = {1'b0, ip_q};
      end
    endcase
    if (wpush && (wbase < SPW'(STACK_DEPTH))) begin
      sp_d = wbase + SPW'(1);
    end else if (wpush) begin
      sp_d = wbase;
    end
    ip_d      = nxt[IpW-1:0];
    stopped_d = 1'b0;
    if (stat_d != ST_RUN) begin
      stopped_d = 1'b1;
    end else if (nxt >= {1'b0, len_q}) begin
      stopped_d = 1'b1;
      stat_d    = ST_HALT;
    end
  end

  // stack write port: clearing pass or write back
  always_comb begin
    st_we    = 1'b0;
    st_waddr = clr_q;
    st_wdata = '0;
    if (state_q == S_CLEAR) begin
      st_we = 1'b1;
    end else if (state_q == S_WB) begin
      if (wstore) begin
        st_we    = 1'b1;
        st_waddr = idx_q[AW-1:0];
        st_wdata = t1_q;
      end else if (wpush && (wbase < SPW'(STACK_DEPTH))) begin
        st_we    = 1'b1;
        st_waddr = wbase[AW-1:0];
        st_wdata = wval;
      end
    end
  end

  // shared 32x32 multiplier operands
  logic [31:0] mul_a, mul_b;
  always_comb begin
    case (mstep_q)
      2'd0:    begin mul_a = t2_q[31:0];  mul_b = t1_q[31:0];  end
      2'd1:    begin mul_a = t2_q[31:0];  mul_b = t1_q[63:32]; end
      default: begin mul_a = t2_q[63:32]; mul_b = t1_q[31:0];  end
    endcase
  end

  // one restoring divide step
  logic [WordW:0] rem_sh, rem_diff;
  assign rem_sh   = {rem_q[WordW-1:0], quo_q[WordW-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_q};

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      sp_q      <= '0;
      fb_q      <= '0;
      ip_q      <= '0;
      cnt_q     <= '0;
      stopped_q <= 1'b0;
      len_q     <= '0;
      done_q    <= 1'b0;
      mstep_q   <= '0;
      dcnt_q    <= '0;
      op_q      <= '0;
      arg_q     <= '0;
      idx_q     <= '0;
      t1_q      <= '0;
      t2_q      <= '0;
      res_q     <= '0;
      divz_q    <= 1'b0;
      mprod_q   <= '0;
      acc_q     <= '0;
      rem_q     <= '0;
      quo_q     <= '0;
      dvs_q     <= '0;
      dneg_q    <= 1'b0;
      pvalid_q  <= 1'b0;
      nip_q     <= '0;
      stat_q    <= '0;
      pval_q    <= '0;
      dep_q     <= '0;
    end else begin
      done_q <= done_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(STACK_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q  <= instr_word_i[7:0];
            arg_q <= instr_word_i[31:8];
            idx_q <= idx_d;
            if (!kind_i) begin
              nip_q    <= ip_q;
              stat_q   <= pool_we ? ST_RUN : ST_FULL;
              pvalid_q <= 1'b0;
              pval_q   <= '0;
              dep_q    <= sp_q;
              if (pool_we) begin
                cnt_q <= cnt_q + CW'(1);
              end
            end else if (stopped_q || (ip_q >= len_q)) begin
              stopped_q <= 1'b1;
              nip_q     <= ip_q;
              stat_q    <= ST_HALT;
              pvalid_q  <= 1'b0;
              pval_q    <= '0;
              dep_q     <= sp_q;
            end else begin
              state_q <= S_RD1;
            end
          end
        end
        S_RD1: begin
          t1_q    <= (sp_q == '0) ? '0 : st_rd_q;
          state_q <= S_RD2;
        end
        S_RD2: begin
          t2_q    <= (op_q == OP_LOAD || sp_q >= SPW'(2)) ? st_rd_q : '0;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          divz_q <= (op_q == OP_DIV) && (t1_q == '0);
          if (op_q == OP_MUL) begin
            state_q <= S_MUL;
          end else if ((op_q == OP_DIV) && (t1_q != '0)) begin
            state_q <= S_DIV;
          end else begin
            state_q <= S_WB;
          end
          case (op_q)
            OP_ADD: res_q <= t2_q + t1_q;
            OP_SUB: res_q <= t2_q - t1_q;
            OP_NEG: res_q <= '0 - t1_q;
            OP_NOT: res_q <= WordW'(t1_q == '0);
            OP_AND: res_q <= WordW'((t2_q != '0) && (t1_q != '0));
            OP_OR:  res_q <= WordW'((t2_q != '0) || (t1_q != '0));
            OP_MUL: mstep_q <= '0;
            OP_DIV: begin
              if (t1_q != '0) begin
                dneg_q <= t2_q[WordW-1] ^ t1_q[WordW-1];
                rem_q  <= '0;
                quo_q  <= t2_q[WordW-1] ? '0 - t2_q : t2_q;
                dvs_q  <= t1_q[WordW-1] ? '0 - t1_q : t1_q;
                dcnt_q <= 7'(WordW);
              end
            end
            default: res_q <= '0;
          endcase
        end
        S_MUL: begin
          mstep_q <= mstep_q + 2'd1;
          mprod_q <= mul_a * mul_b;
          case (mstep_q)
            2'd1: acc_q <= mprod_q;
            2'd2: acc_q <= acc_q + {mprod_q[31:0], 32'd0};
            2'd3: begin
              res_q   <= acc_q + {mprod_q[31:0], 32'd0};
              state_q <= S_WB;
            end
            default: acc_q <= '0;
          endcase
        end
        S_DIV: begin
          dcnt_q <= dcnt_q - 7'd1;
          if (!rem_diff[WordW]) begin
            rem_q <= rem_diff;
            quo_q <= {quo_q[WordW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[WordW-2:0], 1'b0};
          end
          if (dcnt_q == 7'd1) begin
            state_q <= S_DFIN;
          end
        end
        S_DFIN: begin
          res_q   <= dneg_q ? '0 - quo_q : quo_q;
          state_q <= S_WB;
        end
        S_WB: begin
          sp_q      <= sp_d;
          fb_q      <= fb_d;
          ip_q      <= ip_d;
          stopped_q <= stopped_d;
          nip_q     <= ip_d;
          stat_q    <= stat_d;
          pvalid_q  <= wpv;
          pval_q    <= wpv ? t1_q : '0;
          dep_q     <= sp_d;
          state_q   <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result ports
  assign done_o        = done_q;
  assign next_ip_o     = nip_q;
  assign status_o      = stat_q;
  assign print_valid_o = pvalid_q && done_q;
  assign print_value_o = pval_q;
  assign depth_now_o   = 9'(dep_q);

`ifndef SYNTHESIS
  // stack pointer never passes the stack size
  assert property (@(posedge clk_i) disable iff (!rst_ni) sp_q <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond stack size");

  // a running execute always reaches the first read state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i && !stopped_q && (ip_q < len_q)) |=> (state_q == S_RD1))
    else $error("execute transaction not started");

  // a stopping status leaves the core stopped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (stat_q == ST_HALT || stat_q == ST_DIVZ || stat_q == ST_UNK)) |-> stopped_q)
    else $error("stop status without stopped flag");

  // print output only comes with a result
  assert property (@(posedge clk_i) disable iff (!rst_ni) print_valid_o |-> done_o)
    else $error("print without result strobe");
`endif

endmodule
`default_nettype wire
